// ===== hdl/ecvm_pkg.sv =====
// ----------------------------------------------------------------------------
// ecvm_pkg
// Shared types, constants and the sequencer program for the camera view
// matrix engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ecvm_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int POS_BITS     = 32;
  localparam int BAS_FRAC     = 14;
  localparam int BAS_W        = 16;
  localparam int VAL_W        = 32;
  localparam int SHF_W        = 32;
  localparam int BAS_ONE      = 1 << BAS_FRAC;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_FRAC  = 30;
  localparam int COR_W        = 32;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam logic signed [COR_W-1:0] CORDIC_START = 32'sd652032874;

  localparam int MUL_A_W = 32;
  localparam int PROD_W  = MUL_A_W + BAS_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam int UPD_LEN = 54;
  localparam int TRN_LEN = 15;
  localparam int STEP_W  = $clog2(UPD_LEN);

  localparam logic signed [COR_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41721,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef enum logic [1:0] {
    REQ_ROTATE    = 2'd0,
    REQ_TRANSLATE = 2'd1,
    REQ_UPDATE    = 2'd2,
    REQ_PLACE     = 2'd3
  } ecvm_req_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COR_INIT, ST_COR_RUN, ST_COR_STORE, ST_MAC, ST_DONE
  } ecvm_state_e;

  // multiplier a operand: sines/cosines, product scratch, position, request values
  typedef enum logic [3:0] {
    A_SP, A_CP, A_SY, A_CY, A_SR, A_CR, A_TMP,
    A_POS0, A_POS1, A_POS2, A_V0, A_V1, A_V2
  } ecvm_asel_e;

  // multiplier b operand: sines/cosines, one, basis terms
  typedef enum logic [3:0] {
    B_SP, B_CP, B_SY, B_CY, B_SR, B_CR, B_ONE,
    B_BAS0, B_BAS1, B_BAS2, B_BAS3, B_BAS4, B_BAS5, B_BAS6, B_BAS7, B_BAS8
  } ecvm_bsel_e;

  typedef enum logic [2:0] {
    OP_NOP, OP_TMP, OP_LOAD, OP_LNEG, OP_ADD, OP_SUB
  } ecvm_op_e;

  typedef enum logic [2:0] {
    WB_NONE, WB_R2, WB_R3, WB_POS, WB_DOT
  } ecvm_wb_e;

  typedef struct packed {
    ecvm_asel_e asel;
    ecvm_bsel_e bsel;
    ecvm_op_e   op;
    ecvm_wb_e   wb;
    logic [3:0] widx;
  } ecvm_uop_t;

  typedef struct packed {
    logic              cap_en;
    logic              rot_en;
    logic              place_en;
    logic              cor_init;
    logic              cor_step;
    logic              cor_store;
    logic [1:0]        ang_idx;
    logic [ITER_W-1:0] iter;
    ecvm_uop_t         uop;
    logic              out_load;
  } ecvm_cmd_t;

  function automatic ecvm_uop_t uop(input ecvm_asel_e a, input ecvm_bsel_e b,
                                    input ecvm_op_e o, input ecvm_wb_e w,
                                    input logic [3:0] i);
    ecvm_uop_t u;
    u.asel = a;
    u.bsel = b;
    u.op   = o;
    u.wb   = w;
    u.widx = i;
    return u;
  endfunction

  localparam ecvm_uop_t UOP_NOP = '{A_SP, B_ONE, OP_NOP, WB_NONE, 4'd0};

  // products issue in a step and are registered in prod_q, the accumulator
  // takes them from prod_q, and write-back reads the registered accumulator
  function automatic ecvm_uop_t ecvm_ucode(input logic trn, input logic [STEP_W-1:0] s);
    ecvm_uop_t u;
    u = UOP_NOP;
    if (trn) begin
      case (s)
        6'd0:  u = uop(A_V0, B_BAS0, OP_NOP,  WB_NONE, 4'd0);
        6'd1:  u = uop(A_V1, B_BAS3, OP_LOAD, WB_NONE, 4'd0);
        6'd2:  u = uop(A_V2, B_BAS6, OP_ADD,  WB_NONE, 4'd0);
        6'd3:  u = uop(A_SP, B_ONE,  OP_ADD,  WB_NONE, 4'd0);
        6'd4:  u = uop(A_SP, B_ONE,  OP_NOP,  WB_POS,  4'd0);
        6'd5:  u = uop(A_V0, B_BAS1, OP_NOP,  WB_NONE, 4'd0);
        6'd6:  u = uop(A_V1, B_BAS4, OP_LOAD, WB_NONE, 4'd0);
        6'd7:  u = uop(A_V2, B_BAS7, OP_ADD,  WB_NONE, 4'd0);
        6'd8:  u = uop(A_SP, B_ONE,  OP_ADD,  WB_NONE, 4'd0);
        6'd9:  u = uop(A_SP, B_ONE,  OP_NOP,  WB_POS,  4'd1);
        6'd10: u = uop(A_V0, B_BAS2, OP_NOP,  WB_NONE, 4'd0);
        6'd11: u = uop(A_V1, B_BAS5, OP_LOAD, WB_NONE, 4'd0);
        6'd12: u = uop(A_V2, B_BAS8, OP_ADD,  WB_NONE, 4'd0);
        6'd13: u = uop(A_SP, B_ONE,  OP_ADD,  WB_NONE, 4'd0);
        6'd14: u = uop(A_SP, B_ONE,  OP_NOP,  WB_POS,  4'd2);
        default: u = UOP_NOP;
      endcase
    end else begin
      case (s)
        // right x: cy*cr*one + sy*sp*sr
        6'd0:  u = uop(A_CY,  B_CR,  OP_NOP,  WB_NONE, 4'd0);
        6'd1:  u = uop(A_SY,  B_SP,  OP_TMP,  WB_NONE, 4'd0);
        6'd2:  u = uop(A_TMP, B_ONE, OP_TMP,  WB_NONE, 4'd0);
        6'd3:  u = uop(A_TMP, B_SR,  OP_LOAD, WB_NONE, 4'd0);
        6'd4:  u = uop(A_SP,  B_ONE, OP_ADD,  WB_NONE, 4'd0);
        6'd5:  u = uop(A_SP,  B_ONE, OP_NOP,  WB_R3,   4'd0);
        // right z: cy*sp*sr - sy*cr*one
        6'd6:  u = uop(A_CY,  B_SP,  OP_NOP,  WB_NONE, 4'd0);
        6'd7:  u = uop(A_SY,  B_CR,  OP_TMP,  WB_NONE, 4'd0);
        6'd8:  u = uop(A_TMP, B_SR,  OP_TMP,  WB_NONE, 4'd0);
        6'd9:  u = uop(A_TMP, B_ONE, OP_LOAD, WB_NONE, 4'd0);
        6'd10: u = uop(A_SP,  B_ONE, OP_SUB,  WB_NONE, 4'd0);
        6'd11: u = uop(A_SP,  B_ONE, OP_NOP,  WB_R3,   4'd2);
        // up x: sy*sp*cr - cy*sr*one
        6'd12: u = uop(A_SY,  B_SP,  OP_NOP,  WB_NONE, 4'd0);
        6'd13: u = uop(A_CY,  B_SR,  OP_TMP,  WB_NONE, 4'd0);
        6'd14: u = uop(A_TMP, B_CR,  OP_TMP,  WB_NONE, 4'd0);
        6'd15: u = uop(A_TMP, B_ONE, OP_LOAD, WB_NONE, 4'd0);
        6'd16: u = uop(A_SP,  B_ONE, OP_SUB,  WB_NONE, 4'd0);
        6'd17: u = uop(A_SP,  B_ONE, OP_NOP,  WB_R3,   4'd3);
        // up z: sr*sy*one + cr*cy*sp
        6'd18: u = uop(A_SR,  B_SY,  OP_NOP,  WB_NONE, 4'd0);
        6'd19: u = uop(A_CR,  B_CY,  OP_TMP,  WB_NONE, 4'd0);
        6'd20: u = uop(A_TMP, B_ONE, OP_TMP,  WB_NONE, 4'd0);
        6'd21: u = uop(A_TMP, B_SP,  OP_LOAD, WB_NONE, 4'd0);
        6'd22: u = uop(A_SP,  B_ONE, OP_ADD,  WB_NONE, 4'd0);
        6'd23: u = uop(A_SP,  B_ONE, OP_NOP,  WB_R3,   4'd5);
        // two-factor terms
        6'd24: u = uop(A_SR,  B_CP,  OP_NOP,  WB_NONE, 4'd0);
        6'd25: u = uop(A_SP,  B_ONE, OP_LOAD, WB_NONE, 4'd0);
        6'd26: u = uop(A_SP,  B_ONE, OP_NOP,  WB_R2,   4'd1);
        6'd27: u = uop(A_CR,  B_CP,  OP_NOP,  WB_NONE, 4'd0);
        6'd28: u = uop(A_SP,  B_ONE, OP_LOAD, WB_NONE, 4'd0);
        6'd29: u = uop(A_SP,  B_ONE, OP_NOP,  WB_R2,   4'd4);
        6'd30: u = uop(A_CP,  B_SY,  OP_NOP,  WB_NONE, 4'd0);
        6'd31: u = uop(A_SP,  B_ONE, OP_LOAD, WB_NONE, 4'd0);
        6'd32: u = uop(A_SP,  B_ONE, OP_NOP,  WB_R2,   4'd6);
        6'd33: u = uop(A_CP,  B_CY,  OP_NOP,  WB_NONE, 4'd0);
        6'd34: u = uop(A_SP,  B_ONE, OP_LOAD, WB_NONE, 4'd0);
        6'd35: u = uop(A_SP,  B_ONE, OP_NOP,  WB_R2,   4'd8);
        // dir y: -sp
        6'd36: u = uop(A_SP,  B_ONE, OP_NOP,  WB_NONE, 4'd0);
        6'd37: u = uop(A_SP,  B_ONE, OP_LNEG, WB_NONE, 4'd0);
        6'd38: u = uop(A_SP,  B_ONE, OP_NOP,  WB_R2,   4'd7);
        // dot products with the new basis
        6'd39: u = uop(A_POS0, B_BAS0, OP_NOP,  WB_NONE, 4'd0);
        6'd40: u = uop(A_POS1, B_BAS1, OP_LOAD, WB_NONE, 4'd0);
        6'd41: u = uop(A_POS2, B_BAS2, OP_ADD,  WB_NONE, 4'd0);
        6'd42: u = uop(A_SP,   B_ONE,  OP_ADD,  WB_NONE, 4'd0);
        6'd43: u = uop(A_SP,   B_ONE,  OP_NOP,  WB_DOT,  4'd0);
        6'd44: u = uop(A_POS0, B_BAS3, OP_NOP,  WB_NONE, 4'd0);
        6'd45: u = uop(A_POS1, B_BAS4, OP_LOAD, WB_NONE, 4'd0);
        6'd46: u = uop(A_POS2, B_BAS5, OP_ADD,  WB_NONE, 4'd0);
        6'd47: u = uop(A_SP,   B_ONE,  OP_ADD,  WB_NONE, 4'd0);
        6'd48: u = uop(A_SP,   B_ONE,  OP_NOP,  WB_DOT,  4'd1);
        6'd49: u = uop(A_POS0, B_BAS6, OP_NOP,  WB_NONE, 4'd0);
        6'd50: u = uop(A_POS1, B_BAS7, OP_LOAD, WB_NONE, 4'd0);
        6'd51: u = uop(A_POS2, B_BAS8, OP_ADD,  WB_NONE, 4'd0);
        6'd52: u = uop(A_SP,   B_ONE,  OP_ADD,  WB_NONE, 4'd0);
        6'd53: u = uop(A_SP,   B_ONE,  OP_NOP,  WB_DOT,  4'd2);
        default: u = UOP_NOP;
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ecvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecvm_ctrl
// Controller: request decode, cordic sequencing, multiply program stepping
// and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ecvm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ecvm_pkg::ecvm_cmd_t cmd_o
);
  import ecvm_pkg::*;

  ecvm_state_e       st_q, st_d;
  logic [1:0]        ang_idx_q, ang_idx_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              trn_q, trn_d;
  logic              out_vld_q, out_vld_d;
  logic              in_acc;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      ang_idx_q <= '0;
      iter_q    <= '0;
      step_q    <= '0;
      trn_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      ang_idx_q <= ang_idx_d;
      iter_q    <= iter_d;
      step_q    <= step_d;
      trn_q     <= trn_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    st_d          = st_q;
    ang_idx_d     = ang_idx_q;
    iter_d        = iter_q;
    step_d        = step_q;
    trn_d         = trn_q;
    cmd_o         = '0;
    cmd_o.ang_idx = ang_idx_q;
    cmd_o.iter    = iter_q;
    cmd_o.uop     = UOP_NOP;
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_en = 1'b1;
          case (ecvm_req_e'(req_type_i))
            REQ_ROTATE: cmd_o.rot_en = 1'b1;
            REQ_PLACE:  cmd_o.place_en = 1'b1;
            REQ_TRANSLATE: begin
              trn_d  = 1'b1;
              step_d = '0;
              st_d   = ST_MAC;
            end
            REQ_UPDATE: begin
              ang_idx_d = '0;
              st_d      = ST_COR_INIT;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_COR_INIT: begin
        cmd_o.cor_init = 1'b1;
        iter_d         = '0;
        st_d           = ST_COR_RUN;
      end
      ST_COR_RUN: begin
        cmd_o.cor_step = 1'b1;
        iter_d         = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
          st_d = ST_COR_STORE;
        end
      end
      ST_COR_STORE: begin
        cmd_o.cor_store = 1'b1;
        if (ang_idx_q == 2'd2) begin
          trn_d  = 1'b0;
          step_d = '0;
          st_d   = ST_MAC;
        end else begin
          ang_idx_d = ang_idx_q + 2'd1;
          st_d      = ST_COR_INIT;
        end
      end
      ST_MAC: begin
        cmd_o.uop = ecvm_ucode(trn_q, step_q);
        step_d    = step_q + STEP_W'(1);
        if (trn_q && step_q == STEP_W'(TRN_LEN - 1)) begin
          st_d = ST_IDLE;
        end else if (!trn_q && step_q == STEP_W'(UPD_LEN - 1)) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          st_d           = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  // an update request always starts the first cordic pass
  a_upd_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_type_i == REQ_UPDATE) |=> (st_q == ST_COR_INIT && ang_idx_q == 2'd0))
    else $error("update did not start the cordic pass");

  // a pending result is never overwritten while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_vld_q || !out_stall_i))
    else $error("result overwritten while stalled");

  // only three angles per update
  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_COR_INIT || st_q == ST_COR_RUN || st_q == ST_COR_STORE) |-> ang_idx_q != 2'd3)
    else $error("angle index out of range");

  // a translate never produces a result
  a_trn_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MAC && trn_q) |=> !$rose(out_vld_q))
    else $error("translate raised a result");

endmodule

`default_nettype wire

// ===== hdl/ecvm_dp.sv =====
// ----------------------------------------------------------------------------
// ecvm_dp
// Datapath: camera state, shared cordic, shared multiply-accumulate with
// rounding write-back, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecvm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ecvm_pkg::ecvm_cmd_t                 cmd_i,
  input  logic signed [ecvm_pkg::VAL_W-1:0]   value_x_i,
  input  logic signed [ecvm_pkg::VAL_W-1:0]   value_y_i,
  input  logic signed [ecvm_pkg::VAL_W-1:0]   value_z_i,
  output logic signed [ecvm_pkg::BAS_W-1:0]   out_bas_o [9],
  output logic signed [ecvm_pkg::SHF_W-1:0]   out_shf_o [3]
);
  import ecvm_pkg::*;

  localparam logic signed [ACC_W-1:0] ONE_A   = ACC_W'(BAS_ONE);
  localparam logic signed [ACC_W-1:0] HALF_R2 = ACC_W'(1) <<< (BAS_FRAC - 1);
  localparam logic signed [ACC_W-1:0] HALF_R3 = ACC_W'(1) <<< (2 * BAS_FRAC - 1);
  localparam logic signed [ACC_W-1:0] HALF_C  = ACC_W'(1) <<< (CORDIC_FRAC - BAS_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI  = (ACC_W'(1) <<< (SHF_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO  = -(ACC_W'(1) <<< (SHF_W - 1));

  function automatic logic signed [BAS_W-1:0] clamp_one(input logic signed [ACC_W-1:0] v);
    logic signed [BAS_W-1:0] r;
    if (v > ONE_A) begin
      r = BAS_W'(ONE_A);
    end else if (v < -ONE_A) begin
      r = BAS_W'(-ONE_A);
    end else begin
      r = BAS_W'(v);
    end
    return r;
  endfunction

  logic        [ANGLE_BITS-1:0] ang_q [3];
  logic signed [POS_BITS-1:0]   pos_q [3];
  logic signed [BAS_W-1:0]      bas_q [9];
  logic signed [VAL_W-1:0]      v_q   [3];
  logic signed [BAS_W-1:0]      sc_q  [6];
  logic signed [SHF_W-1:0]      shf_q [3];
  logic signed [COR_W-1:0]      cx_q, cy_q, cz_q;
  logic signed [MUL_A_W-1:0]    tmp_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [ACC_W-1:0]      acc_q;

  logic signed [VAL_W-1:0]      vin [3];
  logic        [ANGLE_BITS-1:0] ang_sel;
  logic        [31:0]           turn;
  logic signed [COR_W-1:0]      xs, ys, atan_v;
  logic signed [COR_W:0]        c_raw, s_raw;
  logic signed [BAS_W-1:0]      sin_r, cos_r;
  logic signed [MUL_A_W-1:0]    a_val;
  logic signed [BAS_W-1:0]      b_val;
  logic signed [PROD_W-1:0]     prod_d;
  logic signed [ACC_W-1:0]      prod_x, rnd2, rnd3, neg2;
  logic signed [SHF_W-1:0]      dot_sat;

  assign vin[0] = value_x_i;
  assign vin[1] = value_y_i;
  assign vin[2] = value_z_i;

  // cordic
  assign ang_sel = ang_q[cmd_i.ang_idx];
  assign turn    = {ang_sel, {(32 - ANGLE_BITS){1'b0}}};
  assign xs      = cx_q >>> cmd_i.iter;
  assign ys      = cy_q >>> cmd_i.iter;
  assign atan_v  = ATAN_TBL[cmd_i.iter];

  always_comb begin
    case (turn[31:30])
      2'd0: begin
        c_raw = (COR_W+1)'(cx_q);
        s_raw = (COR_W+1)'(cy_q);
      end
      2'd1: begin
        c_raw = -(COR_W+1)'(cy_q);
        s_raw = (COR_W+1)'(cx_q);
      end
      2'd2: begin
        c_raw = -(COR_W+1)'(cx_q);
        s_raw = -(COR_W+1)'(cy_q);
      end
      default: begin
        c_raw = (COR_W+1)'(cy_q);
        s_raw = -(COR_W+1)'(cx_q);
      end
    endcase
  end

  assign sin_r = clamp_one((ACC_W'(s_raw) + HALF_C) >>> (CORDIC_FRAC - BAS_FRAC));
  assign cos_r = clamp_one((ACC_W'(c_raw) + HALF_C) >>> (CORDIC_FRAC - BAS_FRAC));

  // multiplier operands
  always_comb begin
    case (cmd_i.uop.asel)
      A_SP:    a_val = MUL_A_W'(sc_q[0]);
      A_CP:    a_val = MUL_A_W'(sc_q[1]);
      A_SY:    a_val = MUL_A_W'(sc_q[2]);
      A_CY:    a_val = MUL_A_W'(sc_q[3]);
      A_SR:    a_val = MUL_A_W'(sc_q[4]);
      A_CR:    a_val = MUL_A_W'(sc_q[5]);
      A_TMP:   a_val = tmp_q;
      A_POS0:  a_val = MUL_A_W'(pos_q[0]);
      A_POS1:  a_val = MUL_A_W'(pos_q[1]);
      A_POS2:  a_val = MUL_A_W'(pos_q[2]);
      A_V0:    a_val = MUL_A_W'(v_q[0]);
      A_V1:    a_val = MUL_A_W'(v_q[1]);
      A_V2:    a_val = MUL_A_W'(v_q[2]);
      default: a_val = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.uop.bsel)
      B_SP:    b_val = sc_q[0];
      B_CP:    b_val = sc_q[1];
      B_SY:    b_val = sc_q[2];
      B_CY:    b_val = sc_q[3];
      B_SR:    b_val = sc_q[4];
      B_CR:    b_val = sc_q[5];
      B_ONE:   b_val = BAS_W'(BAS_ONE);
      B_BAS0:  b_val = bas_q[0];
      B_BAS1:  b_val = bas_q[1];
      B_BAS2:  b_val = bas_q[2];
      B_BAS3:  b_val = bas_q[3];
      B_BAS4:  b_val = bas_q[4];
      B_BAS5:  b_val = bas_q[5];
      B_BAS6:  b_val = bas_q[6];
      B_BAS7:  b_val = bas_q[7];
      default: b_val = bas_q[8];
    endcase
  end

  assign prod_d = PROD_W'(a_val) * PROD_W'(b_val);
  assign prod_x = ACC_W'(prod_q);

  // write-back rounding
  assign rnd2 = (acc_q + HALF_R2) >>> BAS_FRAC;
  assign rnd3 = (acc_q + HALF_R3) >>> (2 * BAS_FRAC);
  assign neg2 = -rnd2;

  always_comb begin
    if (neg2 > SAT_HI) begin
      dot_sat = SHF_W'(SAT_HI);
    end else if (neg2 < SAT_LO) begin
      dot_sat = SHF_W'(SAT_LO);
    end else begin
      dot_sat = SHF_W'(neg2);
    end
  end

  // architectural camera state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        ang_q[k] <= '0;
        pos_q[k] <= '0;
      end
      for (int k = 0; k < 9; k++) begin
        bas_q[k] <= (k == 0 || k == 4 || k == 8) ? BAS_W'(BAS_ONE) : '0;
      end
    end else begin
      if (cmd_i.rot_en) begin
        for (int k = 0; k < 3; k++) begin
          ang_q[k] <= ang_q[k] + vin[k][ANGLE_BITS-1:0];
        end
      end
      if (cmd_i.place_en) begin
        for (int k = 0; k < 3; k++) begin
          ang_q[k] <= '0;
          pos_q[k] <= POS_BITS'(vin[k]);
        end
        for (int k = 0; k < 9; k++) begin
          bas_q[k] <= (k == 0 || k == 4 || k == 8) ? BAS_W'(BAS_ONE) : '0;
        end
      end
      case (cmd_i.uop.wb)
        WB_R2:   bas_q[cmd_i.uop.widx] <= clamp_one(rnd2);
        WB_R3:   bas_q[cmd_i.uop.widx] <= clamp_one(rnd3);
        WB_POS:  pos_q[cmd_i.uop.widx[1:0]] <= pos_q[cmd_i.uop.widx[1:0]]
                                               + rnd2[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      for (int k = 0; k < 3; k++) begin
        v_q[k] <= vin[k];
      end
    end
    if (cmd_i.cor_init) begin
      cx_q <= CORDIC_START;
      cy_q <= '0;
      cz_q <= COR_W'({2'b00, turn[29:0]});
    end else if (cmd_i.cor_step) begin
      if (!cz_q[COR_W-1]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atan_v;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atan_v;
      end
    end
    if (cmd_i.cor_store) begin
      sc_q[{cmd_i.ang_idx, 1'b0}] <= sin_r;
      sc_q[{cmd_i.ang_idx, 1'b1}] <= cos_r;
    end

    prod_q <= prod_d;
    case (cmd_i.uop.op)
      OP_TMP:  tmp_q <= prod_q[MUL_A_W-1:0];
      OP_LOAD: acc_q <= prod_x;
      OP_LNEG: acc_q <= -prod_x;
      OP_ADD:  acc_q <= acc_q + prod_x;
      OP_SUB:  acc_q <= acc_q - prod_x;
      default: ;
    endcase
    if (cmd_i.uop.wb == WB_DOT) begin
      shf_q[cmd_i.uop.widx[1:0]] <= dot_sat;
    end

    if (cmd_i.out_load) begin
      for (int k = 0; k < 9; k++) begin
        out_bas_o[k] <= bas_q[k];
      end
      for (int k = 0; k < 3; k++) begin
        out_shf_o[k] <= shf_q[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/euler_camera_view_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_camera_view_matrix
// Euler-angle camera engine: keeps angles, position and view basis and
// emits the view matrix terms on each update request.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o with req_type_i and value_*_i;
//   a request is taken on a clock edge with valid high and stall low
//   rotate and place requests finish in the accept cycle, so they can
//   follow each other every cycle
//   a translate request holds the input stalled while it forms three
//   3-term sums through the one shared 32x16 multiplier
//   an update request runs a 24-step cordic once per angle, then a 54-step
//   multiply program for the nine basis terms and three dot products, and
//   finally loads the result register
//   output channel: out_valid_o / out_stall_i carrying the nine basis terms
//   and three shifts; the result register holds while out_stall_i is high
//   and a new request is taken while it waits; a following update waits at
//   its last cycle only if the previous result is still not taken
//   reset: angles and position zero, basis identity, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module euler_camera_view_matrix (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [ecvm_pkg::VAL_W-1:0] value_x_i,
  input  logic signed [ecvm_pkg::VAL_W-1:0] value_y_i,
  input  logic signed [ecvm_pkg::VAL_W-1:0] value_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ecvm_pkg::BAS_W-1:0] right_x_o,
  output logic signed [ecvm_pkg::BAS_W-1:0] right_y_o,
  output logic signed [ecvm_pkg::BAS_W-1:0] right_z_o,
  output logic signed [ecvm_pkg::BAS_W-1:0] up_x_o,
  output logic signed [ecvm_pkg::BAS_W-1:0] up_y_o,
  output logic signed [ecvm_pkg::BAS_W-1:0] up_z_o,
  output logic signed [ecvm_pkg::BAS_W-1:0] dir_x_o,
  output logic signed [ecvm_pkg::BAS_W-1:0] dir_y_o,
  output logic signed [ecvm_pkg::BAS_W-1:0] dir_z_o,
  output logic signed [ecvm_pkg::SHF_W-1:0] shift_right_o,
  output logic signed [ecvm_pkg::SHF_W-1:0] shift_up_o,
  output logic signed [ecvm_pkg::SHF_W-1:0] shift_dir_o
);
  import ecvm_pkg::*;

  ecvm_cmd_t               cmd;
  logic signed [BAS_W-1:0] out_bas [9];
  logic signed [SHF_W-1:0] out_shf [3];

  // controller: request decode, cordic passes, multiply program, output handshake
  ecvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // datapath: camera state, cordic, multiply-accumulate, result register
  ecvm_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .value_x_i (value_x_i),
    .value_y_i (value_y_i),
    .value_z_i (value_z_i),
    .out_bas_o (out_bas),
    .out_shf_o (out_shf)
  );

  // basis order: right, up, direction
  assign right_x_o     = out_bas[0];
  assign right_y_o     = out_bas[1];
  assign right_z_o     = out_bas[2];
  assign up_x_o        = out_bas[3];
  assign up_y_o        = out_bas[4];
  assign up_z_o        = out_bas[5];
  assign dir_x_o       = out_bas[6];
  assign dir_y_o       = out_bas[7];
  assign dir_z_o       = out_bas[8];
  assign shift_right_o = out_shf[0];
  assign shift_up_o    = out_shf[1];
  assign shift_dir_o   = out_shf[2];

endmodule

`default_nettype wire
